@@ rtl/core/blphm_pkg.sv @@
`timescale 1ns / 1ps

package blphm_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int BAND_W   = 3;
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 5;
  localparam int CHANGE_W = 6;
  localparam int CLASS_W  = 2;
  localparam int THR_W    = 11;
  localparam int MS_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // parameter defaults
  localparam int BAND_COUNT_DEF    = 7;
  localparam int HISTORY_DEPTH_DEF = 7;
  localparam int LEVEL_SHIFT_DEF   = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [MS_W-1:0]    QUIET_MAX = '1;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // peak classes
  localparam logic [CLASS_W-1:0] CLASS_GREEN  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_ORANGE = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_RED    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORANGE_FROM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FROM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 2'd3;

  // configuration reset values
  localparam logic [LEVEL_W-1:0] ORANGE_FROM_RST = 5'd16;
  localparam logic [LEVEL_W-1:0] RED_FROM_RST    = 5'd24;
  localparam logic [THR_W-1:0]   LOUD_THR_RST    = 11'd294;
  localparam logic [MS_W-1:0]    HOLD_MS_RST     = 14'd15000;

  function automatic logic [CLASS_W-1:0] class_of(
    input logic [LEVEL_W-1:0] pk,
    input logic [LEVEL_W-1:0] orange_from,
    input logic [LEVEL_W-1:0] red_from
  );
    logic [CLASS_W-1:0] cls;
    if (pk < orange_from) begin
      cls = CLASS_GREEN;
    end else if (pk >= red_from) begin
      cls = CLASS_RED;
    end else begin
      cls = CLASS_ORANGE;
    end
    return cls;
  endfunction

endpackage

@@ rtl/core/band_level_peak_hold_meter_top.sv @@
`timescale 1ns / 1ps

// Band level meter with per-band peak hold and signal-present detection.
// Takes one transaction per clock cycle: func selects a band sample, a
// one-millisecond tick or a clear of every band's newest level. Each
// sample's result passes through the input register, then the result
// register; ticks and clears return nothing. The input stalls only while
// a finished sample result is held by out_stall. All band state lives in
// flip-flops and is updated as the transaction leaves the input register,
// so back-to-back samples on the same band need no stall. The total history
// sum and the sum of newest levels are kept as running registers, so a
// clear is a single subtract. Samples with a band index at or above
// BAND_COUNT, and the unused func code, are dropped. Configuration may be
// written only while no transaction is in flight.
module band_level_peak_hold_meter_top #(
  parameter int BAND_COUNT    = blphm_pkg::BAND_COUNT_DEF,
  parameter int HISTORY_DEPTH = blphm_pkg::HISTORY_DEPTH_DEF,
  parameter int LEVEL_SHIFT   = blphm_pkg::LEVEL_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [blphm_pkg::FUNC_W-1:0]        in_func,
  input  logic [blphm_pkg::BAND_W-1:0]        in_band,
  input  logic [blphm_pkg::SAMPLE_W-1:0]      in_sample,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [blphm_pkg::BAND_W-1:0]        out_band_out,
  output logic [blphm_pkg::LEVEL_W-1:0]       out_level,
  output logic signed [blphm_pkg::CHANGE_W-1:0] out_change,
  output logic [blphm_pkg::LEVEL_W-1:0]       out_peak_level,
  output logic [blphm_pkg::CLASS_W-1:0]       out_peak_class,
  output logic                                out_signal_present,

  input  logic                                cfg_wen,
  input  logic [blphm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blphm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import blphm_pkg::*;

  localparam int BIDX_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int SUM_MAX = 31 * BAND_COUNT * HISTORY_DEPTH;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int NS_W    = $clog2(31 * BAND_COUNT + 1);
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;

  typedef logic [HISTORY_DEPTH-1:0][LEVEL_W-1:0] hist_row_t;

  // configuration
  logic [LEVEL_W-1:0] orange_from_r;
  logic [LEVEL_W-1:0] red_from_r;
  logic [THR_W-1:0]   loud_thr_r;
  logic [MS_W-1:0]    hold_ms_r;

  // input register
  logic                in_valid_r;
  logic [FUNC_W-1:0]   func_r;
  logic [BAND_W-1:0]   band_r;
  logic [SAMPLE_W-1:0] sample_r;

  // band state
  hist_row_t           hist_r   [BAND_COUNT];
  hist_row_t           hist_nxt [BAND_COUNT];
  logic [LEVEL_W-1:0]  peak_r   [BAND_COUNT];
  logic [CLASS_W-1:0]  class_r  [BAND_COUNT];
  logic [SUM_W-1:0]    hist_sum_r, hist_sum_nxt;
  logic [NS_W-1:0]     newest_sum_r, newest_sum_nxt;
  logic [MS_W-1:0]     quiet_r, quiet_nxt;

  // result register
  logic                       out_valid_r;
  logic [BAND_W-1:0]          band_out_r;
  logic [LEVEL_W-1:0]         level_r;
  logic signed [CHANGE_W-1:0] change_r;
  logic [LEVEL_W-1:0]         peak_level_r;
  logic [CLASS_W-1:0]         peak_class_r;
  logic                       present_r;

  // datapath
  logic                       band_ok;
  logic                       is_sample, is_tick, is_clear;
  logic                       out_free, advance, produce;
  logic [BIDX_W-1:0]          bidx;
  logic [SAMPLE_W-1:0]        shifted;
  logic [LEVEL_W-1:0]         lvl;
  hist_row_t                  row;
  logic [LEVEL_W-1:0]         prev, oldest, peak_cur;
  logic                       renew;
  logic [LEVEL_W-1:0]         peak_new;
  logic [CLASS_W-1:0]         class_new;
  logic [SUM_W-1:0]           sum_after;
  logic                       loud;

  assign band_ok   = 32'(band_r) < BAND_COUNT;
  assign is_sample = in_valid_r && (func_r == FUNC_SAMPLE) && band_ok;
  assign is_tick   = in_valid_r && (func_r == FUNC_TICK);
  assign is_clear  = in_valid_r && (func_r == FUNC_CLEAR);

  assign out_free = !out_valid_r || !out_stall;
  assign produce  = is_sample;
  // non-sample transactions retire without touching the result register
  assign advance  = in_valid_r && (!produce || out_free);
  assign in_stall = in_valid_r && !advance;

  assign bidx     = BIDX_W'(band_r);
  assign shifted  = sample_r >> LEVEL_SHIFT;
  assign lvl      = (shifted > SAMPLE_W'(LEVEL_MAX)) ? LEVEL_MAX : shifted[LEVEL_W-1:0];
  assign row      = hist_r[bidx];
  assign prev     = row[0];
  assign oldest   = row[HISTORY_DEPTH-1];
  assign peak_cur = peak_r[bidx];

  assign renew     = lvl >= peak_cur;
  assign peak_new  = renew ? lvl : (peak_cur - LEVEL_W'(1));
  assign class_new = renew ? class_of(lvl, orange_from_r, red_from_r) : class_r[bidx];

  assign sum_after = hist_sum_r - SUM_W'(oldest) + SUM_W'(lvl);
  assign loud      = CMP_W'(sum_after) >= CMP_W'(loud_thr_r);

  always_comb begin
    for (int b = 0; b < BAND_COUNT; b++) begin
      hist_nxt[b] = hist_r[b];
      if (is_clear) begin
        hist_nxt[b][0] = '0;
      end
    end
    if (is_sample) begin
      hist_nxt[bidx] = {row[HISTORY_DEPTH-2:0], lvl};
    end
  end

  always_comb begin
    hist_sum_nxt   = hist_sum_r;
    newest_sum_nxt = newest_sum_r;
    quiet_nxt      = quiet_r;
    if (is_sample) begin
      hist_sum_nxt   = sum_after;
      newest_sum_nxt = newest_sum_r - NS_W'(prev) + NS_W'(lvl);
      if (loud) begin
        quiet_nxt = '0;
      end
    end else if (is_clear) begin
      hist_sum_nxt   = hist_sum_r - SUM_W'(newest_sum_r);
      newest_sum_nxt = '0;
    end else if (is_tick) begin
      if (quiet_r != QUIET_MAX) begin
        quiet_nxt = quiet_r + MS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orange_from_r <= ORANGE_FROM_RST;
      red_from_r    <= RED_FROM_RST;
      loud_thr_r    <= LOUD_THR_RST;
      hold_ms_r     <= HOLD_MS_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_ORANGE_FROM: orange_from_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_RED_FROM:    red_from_r    <= cfg_wdata[LEVEL_W-1:0];
        CFG_LOUD_THR:    loud_thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_HOLD_MS:     hold_ms_r     <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      func_r   <= in_func;
      band_r   <= in_band;
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        hist_r[b]  <= '0;
        peak_r[b]  <= '0;
        class_r[b] <= CLASS_GREEN;
      end
      hist_sum_r   <= '0;
      newest_sum_r <= '0;
      quiet_r      <= '0;
    end else if (advance) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        hist_r[b] <= hist_nxt[b];
      end
      if (is_sample) begin
        peak_r[bidx]  <= peak_new;
        class_r[bidx] <= class_new;
      end
      hist_sum_r   <= hist_sum_nxt;
      newest_sum_r <= newest_sum_nxt;
      quiet_r      <= quiet_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && produce) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      band_out_r   <= band_r;
      level_r      <= lvl;
      change_r     <= signed'(CHANGE_W'(lvl) - CHANGE_W'(prev));
      peak_level_r <= peak_new;
      peak_class_r <= class_new;
      present_r    <= loud || (quiet_r < hold_ms_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_band_out       = band_out_r;
  assign out_level          = level_r;
  assign out_change         = change_r;
  assign out_peak_level     = peak_level_r;
  assign out_peak_class     = peak_class_r;
  assign out_signal_present = present_r;

  // newest levels are part of the full history
  a_newest_in_total: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(newest_sum_r) <= hist_sum_r)
    else $error("newest-level sum exceeds history sum");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hist_sum_r) <= SUM_MAX)
    else $error("history sum out of range");

  // a tick, a clear or a dropped transaction must not disturb a waiting result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !produce) |=> (out_valid_r == $past(out_valid_r && out_stall)))
    else $error("result appeared for a transaction without one");

  a_peak_ge_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (peak_level_r >= level_r))
    else $error("peak hold below newest level");

  a_quiet_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_sample && loud) |=> (quiet_r == '0))
    else $error("quiet timer not cleared on loud sample");

endmodule
